@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define JLPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define JLPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/jlpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlpi_pkg
// Types and constants of the joint path interpolator.
// ----------------------------------------------------------------------------
package jlpi_pkg;

    localparam int DIV_W      = 48;
    localparam int INC_FRAC   = 15;
    localparam int ANGLE_OUTS = 6;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_PLAN = 2'd1;
    localparam logic [1:0] FUNC_PICK = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PLANNED = 2'd1;
    localparam logic [1:0] ST_BEYOND      = 2'd2;
    localparam logic [1:0] ST_TOO_LONG    = 2'd3;

    localparam logic [2:0] REG_STEP_ANGLE = 3'd6;

    localparam logic [30:0] SPEED_RESET = 31'd16777216;
    localparam logic [30:0] STEP_RESET  = 31'd16777;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         axis;
        logic signed [31:0] start_angle;
        logic signed [31:0] target_angle;
        logic [19:0]        stamp;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [19:0]        path_length;
        logic [19:0]        point_stamp;
        logic signed [31:0] angle_axis1;
        logic signed [31:0] angle_axis2;
        logic signed [31:0] angle_axis3;
        logic signed [31:0] angle_axis4;
        logic signed [31:0] angle_axis5;
        logic signed [31:0] angle_axis6;
    } t_out_req;

endpackage

@@ hw/rtl/joint_linear_path_interpolator_top.sv @@
`timescale 1ns / 1ps
// Load goes straight to the hold state. Pick: one shared multiplier, 3 steps per axis.
// Plan: shared multiplier compares the axes, then one bit-serial divider: one path length
// division and one per axis; a zero path skips the per-axis divisions.
// One request at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset clears angles, increments and plan and presets config registers.
// ----------------------------------------------------------------------------
// joint_linear_path_interpolator_top
// Multi-axis joint path planner and interpolator, Q8.24 fixed point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module joint_linear_path_interpolator_top
    import jlpi_pkg::*;
#(
    parameter int AXES       = 6,
    parameter int STAMP_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic [DIV_W-1:0] MAXLEN = (48'd1 << STAMP_BITS) - 48'd1;
    localparam logic [64:0] HALF = 65'd1 << (INC_FRAC - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CMP_A, S_CMP_B, S_LEN_DIV, S_INC_LD, S_INC_DIV,
        S_PICK_A, S_PICK_B, S_PICK_C, S_HOLD
    } t_state;

    t_state r_state;

    logic signed [31:0] r_start  [AXES];
    logic signed [31:0] r_target [AXES];
    logic [46:0]        r_inc_mag [AXES];
    logic               r_inc_neg [AXES];
    logic [30:0]        r_lim [AXES];
    logic [30:0]        r_step_angle;
    logic [STAMP_BITS-1:0] r_count;
    logic               r_planned;

    logic [IDX_W-1:0]   r_idx;
    logic [32:0]        r_dk;
    logic [30:0]        r_limk;
    logic [64:0]        r_prod;
    logic [64:0]        r_acc;
    logic [DIV_W-1:0]   r_num;
    logic [31:0]        r_rem;
    logic [31:0]        r_den;
    logic [5:0]         r_cnt;
    logic [19:0]        r_stamp;
    logic signed [31:0] r_ang [ANGLE_OUTS];
    t_out_req           r_res;
    t_out_req           n_res;
    t_out_req           r_out;
    logic               r_ovalid;

    logic               w_in_acc;
    logic signed [32:0] w_delta;
    logic               w_dneg;
    logic [32:0]        w_dmag;
    logic [30:0]        w_lim_i;
    logic [30:0]        w_sa;
    logic [32:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [64:0]        w_mul_p;
    logic [32:0]        w_rem_sh;
    logic [32:0]        w_rem_sub;
    logic               w_ge;
    logic [DIV_W-1:0]   w_num_nx;
    logic               w_len_over;
    logic [STAMP_BITS-1:0] w_len;
    logic [32:0]        w_len33;
    logic [32:0]        w_cnt33;
    logic [67:0]        w_sum;
    logic [32:0]        w_off;
    logic signed [32:0] w_st33;
    logic [32:0]        w_ang33;
    logic signed [31:0] w_ang;
    logic               w_axis_ok;
    logic               w_div_last;
    logic               w_cmp_win;
    logic [32:0]        w_dk_nx;
    logic               w_hold_go;
    t_out_req           w_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign w_hold_go   = (r_state == S_HOLD) && (!r_ovalid || i_out_ready);

    assign w_delta = {r_target[r_idx][31], r_target[r_idx]}
                   - {r_start[r_idx][31], r_start[r_idx]};
    assign w_dneg  = w_delta[32];
    assign w_dmag  = w_dneg ? 33'(-w_delta) : 33'(w_delta);
    assign w_lim_i = (r_lim[r_idx] == '0) ? 31'd1 : r_lim[r_idx];
    assign w_sa    = (r_step_angle == '0) ? 31'd1 : r_step_angle;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_CMP_A: begin
                w_mul_a = w_dmag;
                w_mul_b = {1'b0, r_limk};
            end
            S_CMP_B: begin
                w_mul_a = r_dk;
                w_mul_b = {1'b0, w_lim_i};
            end
            S_PICK_A: begin
                w_mul_a = {1'b0, r_inc_mag[r_idx][31:0]};
                w_mul_b = {12'd0, r_stamp};
            end
            S_PICK_B: begin
                w_mul_a = {18'd0, r_inc_mag[r_idx][46:32]};
                w_mul_b = {12'd0, r_stamp};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = 65'(w_mul_a) * 65'(w_mul_b);

    // winner of the current compare, seen before it lands in r_dk
    assign w_cmp_win = (r_prod > w_mul_p);
    assign w_dk_nx   = w_cmp_win ? w_dmag : r_dk;

    // restoring divider, one quotient bit per cycle
    assign w_rem_sh   = {r_rem, r_num[DIV_W-1]};
    assign w_ge       = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub  = w_rem_sh - {1'b0, r_den};
    assign w_num_nx   = {r_num[DIV_W-2:0], w_ge};
    assign w_div_last = (r_cnt == 6'(DIV_W - 1));

    assign w_len_over = (w_num_nx > MAXLEN);
    assign w_len      = w_len_over ? '1 : w_num_nx[STAMP_BITS-1:0];
    assign w_len33    = 33'(w_len);
    assign w_cnt33    = 33'(r_count);

    assign w_sum   = 68'(r_acc) + {r_prod[35:0], 32'd0};
    assign w_off   = w_sum[47:15];
    assign w_st33  = {r_start[r_idx][31], r_start[r_idx]};
    assign w_ang33 = r_inc_neg[r_idx] ? 33'(w_st33 - $signed(w_off))
                                      : 33'(w_st33 + $signed(w_off));

    always_comb begin
        if (r_stamp == '0) begin
            w_ang = r_start[r_idx];
        end else if (33'(r_stamp) == w_cnt33) begin
            w_ang = r_target[r_idx];
        end else begin
            w_ang = w_ang33[31:0];
        end
    end

    assign w_axis_ok = ({1'b0, i_in.axis} < 4'(AXES));

    always_comb begin
        n_res = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res = '0;
                    case (i_in.func)
                        FUNC_LOAD: begin
                            if (!w_axis_ok) begin
                                n_res.path_length = w_cnt33[19:0];
                            end
                        end
                        FUNC_PLAN: begin
                            n_res = '0;
                        end
                        FUNC_PICK: begin
                            if (!r_planned) begin
                                n_res.status = ST_NOT_PLANNED;
                            end else if (33'(i_in.stamp) > w_cnt33) begin
                                n_res.status      = ST_BEYOND;
                                n_res.path_length = w_cnt33[19:0];
                            end else begin
                                n_res.path_length = w_cnt33[19:0];
                                n_res.point_stamp = i_in.stamp;
                            end
                        end
                        default: begin
                            n_res.path_length = w_cnt33[19:0];
                        end
                    endcase
                end
            end
            S_LEN_DIV: begin
                if (w_div_last) begin
                    n_res.status      = w_len_over ? ST_TOO_LONG : ST_OK;
                    n_res.path_length = w_len33[19:0];
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_comb begin
        w_res = r_res;
        w_res.angle_axis1 = r_ang[0];
        w_res.angle_axis2 = r_ang[1];
        w_res.angle_axis3 = r_ang[2];
        w_res.angle_axis4 = r_ang[3];
        w_res.angle_axis5 = r_ang[4];
        w_res.angle_axis6 = r_ang[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_planned    <= 1'b0;
            r_count      <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_step_angle <= STEP_RESET;
            for (int i = 0; i < AXES; i++) begin
                r_start[i]   <= '0;
                r_target[i]  <= '0;
                r_inc_mag[i] <= '0;
                r_inc_neg[i] <= 1'b0;
                r_lim[i]     <= SPEED_RESET;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_STEP_ANGLE) begin
                    r_step_angle <= i_cfg_data;
                end else if (i_cfg_idx < REG_STEP_ANGLE && 4'(i_cfg_idx) < 4'(AXES)) begin
                    r_lim[i_cfg_idx[IDX_W-1:0]] <= i_cfg_data;
                end
            end

            r_res <= n_res;

            if (r_ovalid && i_out_ready && !w_hold_go) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_stamp <= i_in.stamp;
                        r_idx   <= '0;
                        for (int j = 0; j < ANGLE_OUTS; j++) begin
                            r_ang[j] <= '0;
                        end
                        case (i_in.func)
                            FUNC_LOAD: begin
                                if (w_axis_ok) begin
                                    r_start[i_in.axis[IDX_W-1:0]]  <= i_in.start_angle;
                                    r_target[i_in.axis[IDX_W-1:0]] <= i_in.target_angle;
                                    r_planned <= 1'b0;
                                    r_count   <= '0;
                                end
                                r_state <= S_HOLD;
                            end
                            FUNC_PLAN: begin
                                r_dk    <= '0;
                                r_limk  <= 31'd1;
                                r_state <= S_CMP_A;
                            end
                            FUNC_PICK: begin
                                if (!r_planned) begin
                                    r_state <= S_HOLD;
                                end else if (33'(i_in.stamp) > w_cnt33) begin
                                    r_state <= S_HOLD;
                                end else begin
                                    r_state <= S_PICK_A;
                                end
                            end
                            default: begin
                                r_state <= S_HOLD;
                            end
                        endcase
                    end
                end
                S_CMP_A: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_CMP_B;
                end
                S_CMP_B: begin
                    if (w_cmp_win) begin
                        r_dk   <= w_dmag;
                        r_limk <= w_lim_i;
                    end
                    if (r_idx == IDX_W'(AXES - 1)) begin
                        r_num   <= 48'(34'(w_dk_nx) + 34'(w_sa) - 34'd1);
                        r_rem   <= '0;
                        r_den   <= {1'b0, w_sa};
                        r_cnt   <= '0;
                        r_state <= S_LEN_DIV;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CMP_A;
                    end
                end
                S_LEN_DIV: begin
                    r_num <= w_num_nx;
                    r_rem <= w_ge ? w_rem_sub[31:0] : w_rem_sh[31:0];
                    r_cnt <= w_div_last ? 6'd0 : r_cnt + 6'd1;
                    if (w_div_last) begin
                        r_count <= w_len;
                        r_idx   <= '0;
                        if (w_len == '0) begin
                            for (int i = 0; i < AXES; i++) begin
                                r_inc_mag[i] <= '0;
                                r_inc_neg[i] <= 1'b0;
                            end
                            r_planned <= 1'b1;
                            r_state   <= S_HOLD;
                        end else begin
                            r_state <= S_INC_LD;
                        end
                    end
                end
                S_INC_LD: begin
                    r_num             <= {w_dmag[32:0], 15'd0};
                    r_rem             <= '0;
                    r_den             <= 32'(r_count);
                    r_cnt             <= '0;
                    r_inc_neg[r_idx]  <= w_dneg;
                    r_state           <= S_INC_DIV;
                end
                S_INC_DIV: begin
                    r_num <= w_num_nx;
                    r_rem <= w_ge ? w_rem_sub[31:0] : w_rem_sh[31:0];
                    r_cnt <= w_div_last ? 6'd0 : r_cnt + 6'd1;
                    if (w_div_last) begin
                        r_inc_mag[r_idx] <= w_num_nx[46:0];
                        if (r_idx == IDX_W'(AXES - 1)) begin
                            r_planned <= 1'b1;
                            r_state   <= S_HOLD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_INC_LD;
                        end
                    end
                end
                S_PICK_A: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_PICK_B;
                end
                S_PICK_B: begin
                    r_acc   <= r_prod + HALF;
                    r_prod  <= w_mul_p;
                    r_state <= S_PICK_C;
                end
                S_PICK_C: begin
                    if (32'(r_idx) < ANGLE_OUTS) begin
                        r_ang[3'(r_idx)] <= w_ang;
                    end
                    if (r_idx == IDX_W'(AXES - 1)) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_PICK_A;
                    end
                end
                S_HOLD: begin
                    if (w_hold_go) begin
                        r_out    <= w_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `JLPI_ASSERT(a_plan_drop, i_clk, i_rst_n, $fell(r_planned) |-> $past(w_in_acc && i_in.func == FUNC_LOAD), "plan dropped without load")
    `JLPI_ASSERT(a_div_cnt, i_clk, i_rst_n, (r_cnt != '0) |-> (r_state == S_LEN_DIV || r_state == S_INC_DIV), "divider count outside division")
    `JLPI_ASSERT(a_out_src, i_clk, i_rst_n, $rose(r_ovalid) |-> $past(r_state == S_HOLD), "result not from hold state")
    `JLPI_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Joint path interpolator testbench: directed table of load/plan/pick requests
// with typed-in results where obvious, then random path sequences under
// several idle/stall phases, the rest checked against a behavioral path model.
// ----------------------------------------------------------------------------
module tb_top;
    import jlpi_pkg::*;

    localparam int NAXES = 6;
    localparam int FRAC = 15;
    localparam longint MAXLEN = (64'd1 << 20) - 1;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_req     in_req;
    logic        out_valid;
    logic        out_ready;
    t_out_req    out_req;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [30:0] cfg_data;

    joint_linear_path_interpolator_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_req),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_req),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // path model state
    longint   start_a [NAXES];
    longint   target_a[NAXES];
    longint   incr    [NAXES];
    longint   path_len;
    bit       is_planned;
    longint   speed   [NAXES];
    longint   step_ang;

    t_out_req point_queue[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_off;
    int       idle_cycles;
    bit       failed;

    typedef struct {
        t_in_req  req;
        bit       has_exp;
        t_out_req exp;
    } t_row;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_out_req predict_point(t_in_req r);
        t_out_req o;
        longint a[NAXES];
        longint dk, lk, d, l, sa, q, m, off;
        o = '0;
        case (r.func)
            FUNC_LOAD: begin
                if (r.axis < NAXES) begin
                    start_a[r.axis] = longint'(r.start_angle);
                    target_a[r.axis] = longint'(r.target_angle);
                    is_planned = 0;
                    path_len = 0;
                end
                o.path_length = is_planned ? path_len[19:0] : '0;
            end
            FUNC_PLAN: begin
                lk = speed[0] ? speed[0] : 1;
                dk = abs64(target_a[0] - start_a[0]);
                for (int i = 1; i < NAXES; i++) begin
                    l = speed[i] ? speed[i] : 1;
                    d = abs64(target_a[i] - start_a[i]);
                    if (d * lk > dk * l) begin
                        dk = d;
                        lk = l;
                    end
                end
                sa = step_ang ? step_ang : 1;
                path_len = (dk + sa - 1) / sa;
                if (path_len > MAXLEN) begin
                    path_len = MAXLEN;
                    o.status = ST_TOO_LONG;
                end
                for (int i = 0; i < NAXES; i++) begin
                    d = target_a[i] - start_a[i];
                    q = path_len ? (abs64(d) << FRAC) / path_len : 0;
                    incr[i] = d < 0 ? -q : q;
                end
                is_planned = 1;
                o.path_length = path_len[19:0];
            end
            FUNC_PICK: begin
                if (!is_planned) begin
                    o.status = ST_NOT_PLANNED;
                end else if (longint'(r.stamp) > path_len) begin
                    o.status = ST_BEYOND;
                    o.path_length = path_len[19:0];
                end else begin
                    o.path_length = path_len[19:0];
                    o.point_stamp = r.stamp;
                    for (int i = 0; i < NAXES; i++) begin
                        if (r.stamp == 0) a[i] = start_a[i];
                        else if (longint'(r.stamp) == path_len) a[i] = target_a[i];
                        else begin
                            m = abs64(incr[i]) * longint'(r.stamp);
                            off = (m + (64'd1 << (FRAC - 1))) >>> FRAC;
                            a[i] = incr[i] < 0 ? start_a[i] - off : start_a[i] + off;
                        end
                    end
                    o.angle_axis1 = a[0][31:0];
                    o.angle_axis2 = a[1][31:0];
                    o.angle_axis3 = a[2][31:0];
                    o.angle_axis4 = a[3][31:0];
                    o.angle_axis5 = a[4][31:0];
                    o.angle_axis6 = a[5][31:0];
                end
            end
            default: o.path_length = is_planned ? path_len[19:0] : '0;
        endcase
        return o;
    endfunction

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            $error("%s: expected %0d, actual %0d", name, e, a);
            failed = 1;
        end
    endtask

    // output side
    always @(posedge clk) begin
        t_out_req e;
        if (rst_n && out_valid && out_ready) begin
            if (point_queue.size() == 0) begin
                $error("unexpected result status=%0d", out_req.status);
                failed = 1;
            end else begin
                e = point_queue.pop_front();
                check_field("status", e.status, out_req.status);
                check_field("path_length", e.path_length, out_req.path_length);
                check_field("point_stamp", e.point_stamp, out_req.point_stamp);
                check_field("angle_axis1", e.angle_axis1, out_req.angle_axis1);
                check_field("angle_axis2", e.angle_axis2, out_req.angle_axis2);
                check_field("angle_axis3", e.angle_axis3, out_req.angle_axis3);
                check_field("angle_axis4", e.angle_axis4, out_req.angle_axis4);
                check_field("angle_axis5", e.angle_axis5, out_req.angle_axis5);
                check_field("angle_axis6", e.angle_axis6, out_req.angle_axis6);
            end
        end
    end

    always @(negedge clk) begin
        if (hold_off > 0) begin
            out_ready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // valid stays up after acceptance until the next call replaces or drops it, or drain() drops it
    task automatic send_request(t_in_req r, bit has_exp, t_out_req exp);
        t_out_req p;
        cfg_we <= 0;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_req <= r;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = predict_point(r);
        point_queue.push_back(has_exp ? exp : p);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (point_queue.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    // write enable is dropped by the next send_request()
    task automatic write_reg(logic [2:0] idx, logic [30:0] v);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(negedge clk);
        if (idx == REG_STEP_ANGLE) step_ang = v;
        else speed[idx] = v;
    endtask

    function automatic t_in_req mk(logic [1:0] f, logic [2:0] ax, logic [31:0] s,
                                   logic [31:0] t, logic [19:0] st);
        t_in_req r;
        r.func = f;
        r.axis = ax;
        r.start_angle = s;
        r.target_angle = t;
        r.stamp = st;
        return r;
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
        endcase
    endfunction

    task automatic random_sequence(int n);
        t_in_req r;
        int      k;
        k = 0;
        while (k < n) begin
            if ($urandom_range(9) < 8) begin
                for (int i = 0; i < NAXES; i++) begin
                    if ($urandom_range(3) != 0) begin
                        send_request(mk(FUNC_LOAD, i, rand_angle(), rand_angle(),
                                     $urandom()), 0, '0);
                        k++;
                    end
                end
                send_request(mk(FUNC_PLAN, $urandom(), $urandom(), $urandom(),
                             $urandom()), 0, '0);
                k++;
                repeat ($urandom_range(8, 1)) begin
                    case ($urandom_range(4))
                        0: r = mk(FUNC_PICK, $urandom(), $urandom(), $urandom(), 0);
                        1: r = mk(FUNC_PICK, $urandom(), $urandom(), $urandom(),
                                  path_len[19:0]);
                        2: r = mk(FUNC_PICK, $urandom(), $urandom(), $urandom(),
                                  $urandom());
                        default: r = mk(FUNC_PICK, $urandom(), $urandom(), $urandom(),
                                        path_len ? $urandom_range(path_len) : 0);
                    endcase
                    send_request(r, 0, '0);
                    k++;
                end
            end else begin
                send_request(mk($urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom()), 0, '0);
                k++;
            end
        end
    endtask

    initial begin
        t_row     rows[$];
        t_row     row;
        t_out_req z;
        z = '0;
        failed = 0;
        idle_cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 0;
        in_valid = 0;
        in_req = '0;
        out_ready = 0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_data = '0;
        for (int i = 0; i < NAXES; i++) begin
            start_a[i] = 0;
            target_a[i] = 0;
            incr[i] = 0;
            speed[i] = SPEED_RESET;
        end
        step_ang = STEP_RESET;
        path_len = 0;
        is_planned = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;

        // directed table
        row.has_exp = 1;
        row.exp = z;
        row.exp.status = ST_NOT_PLANNED;
        row.req = mk(FUNC_PICK, 0, 0, 0, 0); rows.push_back(row);
        row.exp = z;
        row.req = mk(FUNC_PLAN, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(FUNC_PICK, 0, 0, 0, 0); rows.push_back(row);
        row.exp.status = ST_BEYOND;
        row.req = mk(FUNC_PICK, 0, 0, 0, 20'hfffff); rows.push_back(row);
        row.exp = z;
        row.req = mk(3, 7, 32'hffff_ffff, 32'hffff_ffff, 20'hfffff); rows.push_back(row);
        row.req = mk(FUNC_LOAD, 7, 32'h1234, 32'h5678, 0); rows.push_back(row);
        row.req = mk(FUNC_LOAD, 0, 32'h8000_0000, 32'h7fff_ffff, 0); rows.push_back(row);
        row.has_exp = 0;
        row.req = mk(FUNC_PLAN, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(FUNC_PICK, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(FUNC_PICK, 0, 0, 0, 20'hfffff); rows.push_back(row);
        row.req = mk(FUNC_PICK, 0, 0, 0, 20'h7ffff); rows.push_back(row);
        row.req = mk(FUNC_LOAD, 0, 32'h0100_0000, 32'hff00_0000, 0); rows.push_back(row);
        row.req = mk(FUNC_LOAD, 1, 32'h7fff_ffff, 32'h8000_0000, 0); rows.push_back(row);
        row.req = mk(FUNC_LOAD, 2, 32'h0000_0001, 32'h0000_0002, 0); rows.push_back(row);
        row.req = mk(FUNC_LOAD, 5, 32'hc000_0000, 32'h4000_0000, 0); rows.push_back(row);
        row.req = mk(FUNC_PLAN, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(FUNC_PICK, 0, 0, 0, 20'd1); rows.push_back(row);
        row.req = mk(FUNC_PICK, 0, 0, 0, 20'd12345); rows.push_back(row);
        foreach (rows[i]) send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
        drain();

        // register extremes: max step angle, then small
        for (int i = 0; i < NAXES; i++) write_reg(i, i[0] ? 31'h7fff_ffff : 31'd1);
        write_reg(REG_STEP_ANGLE, 31'h7fff_ffff);
        send_request(mk(FUNC_PLAN, 0, 0, 0, 0), 0, '0);
        send_request(mk(FUNC_PICK, 0, 0, 0, 20'd1), 0, '0);
        drain();
        write_reg(REG_STEP_ANGLE, 31'd1);
        send_request(mk(FUNC_PLAN, 0, 0, 0, 0), 0, '0);
        send_request(mk(FUNC_PICK, 0, 0, 0, 20'd3), 0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < NAXES; i++)
                write_reg(i, $urandom_range(1) ? $urandom_range(1 << 26, 1)
                                               : $urandom_range(31'h7fff_ffff, 1));
            write_reg(REG_STEP_ANGLE, $urandom_range(3) != 0
                      ? $urandom_range(1 << 24, 1 << 12) : $urandom_range(31'h7fff_ffff, 1));
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (ph == 0) hold_off = 600;
            random_sequence(430);
            drain();
        end

        if (!failed) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end
endmodule
